// ===== hw/rtl/gaussian_pixel_background_nll_defines.svh =====
// Assertion macros shared by the checker of the background likelihood block.
// No dependencies; included by files that assert.
`ifndef GAUSSIAN_PIXEL_BACKGROUND_NLL_DEFINES_SVH
`define GAUSSIAN_PIXEL_BACKGROUND_NLL_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define GPBN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with a fixed delay before the consequent
`define GPBN_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(ante) |-> ##(dly) (cons)) else $error(msg);

`endif

// ===== hw/rtl/gpbn_pkg.sv =====
// Package for the background likelihood block: widths, types and pipeline depth.
// No dependencies; used by every module of the block.
package gpbn_pkg;

	// channel count and covariance fraction bits
	localparam int CHANNELS      = 3;
	localparam int COV_FRAC_BITS = 24;

	localparam int PIX_W  = 8;
	localparam int D_W    = PIX_W + 1;
	localparam int ICOV_W = 32;
	localparam int NLL_W  = 32;
	localparam int PROD_W = D_W + ICOV_W;
	localparam int ROW_W  = PROD_W + 2;
	localparam int LANE_W = ROW_W + D_W;
	localparam int Q_W    = LANE_W + 2;

	// halving and conversion to 16 fraction bits
	localparam int HALF_SHIFT = COV_FRAC_BITS - 15;
	localparam int RSH        = (HALF_SHIFT > 0) ? HALF_SHIFT : 0;
	localparam int LSH        = (HALF_SHIFT < 0) ? -HALF_SHIFT : 0;
	localparam int HALF_W     = Q_W + LSH;
	localparam int TOT_W      = HALF_W + 1;

	// accept edge to result strobe sampling edge
	localparam int LATENCY = 6;

	typedef logic signed [D_W-1:0]    diff_t;
	typedef logic signed [ICOV_W-1:0] icov_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ROW_W-1:0]  row_t;
	typedef logic signed [LANE_W-1:0] lane_t;
	typedef logic signed [Q_W-1:0]    q_t;
	typedef logic signed [NLL_W-1:0]  nll_t;

endpackage

// ===== hw/rtl/gpbn_lane.sv =====
// One matrix-row lane: d_r * sum_c(d_c * icov_rc), three pipeline stages.
// Depends on gpbn_pkg.
module gpbn_lane (
	input  logic              clk,
	input  gpbn_pkg::diff_t   d_all [gpbn_pkg::CHANNELS],
	input  gpbn_pkg::diff_t   d_row,
	input  gpbn_pkg::icov_t   icov_row [gpbn_pkg::CHANNELS],
	output gpbn_pkg::lane_t   lane_s4
);

	gpbn_pkg::prod_t prod_s2 [gpbn_pkg::CHANNELS];
	gpbn_pkg::diff_t d_row_s2;
	gpbn_pkg::row_t  row_s3;
	gpbn_pkg::diff_t d_row_s3;
	gpbn_pkg::row_t  row_sum;

	// column products
	always_ff @(posedge clk) begin
		for (int c = 0; c < gpbn_pkg::CHANNELS; c++) begin
			prod_s2[c] <= gpbn_pkg::PROD_W'(d_all[c]) * gpbn_pkg::PROD_W'(icov_row[c]);
		end
		d_row_s2 <= d_row;
	end

	// row sum
	always_comb begin
		row_sum = '0;
		for (int c = 0; c < gpbn_pkg::CHANNELS; c++) begin
			row_sum = row_sum + gpbn_pkg::ROW_W'(prod_s2[c]);
		end
	end

	always_ff @(posedge clk) begin
		row_s3   <= row_sum;
		d_row_s3 <= d_row_s2;
	end

	// weight by this lane's own difference
	always_ff @(posedge clk) begin
		lane_s4 <= gpbn_pkg::LANE_W'(row_s3) * gpbn_pkg::LANE_W'(d_row_s3);
	end

endmodule

// ===== hw/rtl/gpbn_merge.sv =====
// Merge stage: sums the lanes, halves (rounded or exact), adds normaliser, saturates.
// Depends on gpbn_pkg.
module gpbn_merge (
	input  logic             clk,
	input  gpbn_pkg::lane_t  lane_s4 [gpbn_pkg::CHANNELS],
	input  gpbn_pkg::icov_t  nln_s4,
	output gpbn_pkg::nll_t   nll_s6,
	output logic             sat_s6
);

	gpbn_pkg::q_t    q_sum;
	gpbn_pkg::q_t    q_s5;
	gpbn_pkg::icov_t nln_s5;
	logic signed [gpbn_pkg::HALF_W-1:0] half;
	logic signed [gpbn_pkg::TOT_W-1:0]  total;
	logic [gpbn_pkg::TOT_W-32:0]        upper;
	logic                               fits;

	// quadratic form over all lanes
	always_comb begin
		q_sum = '0;
		for (int r = 0; r < gpbn_pkg::CHANNELS; r++) begin
			q_sum = q_sum + gpbn_pkg::Q_W'(lane_s4[r]);
		end
	end

	always_ff @(posedge clk) begin
		q_s5   <= q_sum;
		nln_s5 <= nln_s4;
	end

	// half of q in Q16.16: round to nearest, ties up, or exact left shift
	if (gpbn_pkg::RSH > 0) begin : g_rsh
		gpbn_pkg::q_t q_bias;
		assign q_bias = q_s5 + (gpbn_pkg::q_t'(1) <<< (gpbn_pkg::RSH - 1));
		assign half   = gpbn_pkg::HALF_W'(q_bias >>> gpbn_pkg::RSH);
	end else begin : g_lsh
		assign half = gpbn_pkg::HALF_W'(q_s5) <<< gpbn_pkg::LSH;
	end

	// add normaliser and clip to 32 bits
	assign total = gpbn_pkg::TOT_W'(half) + gpbn_pkg::TOT_W'(nln_s5);
	assign upper = total[gpbn_pkg::TOT_W-1:31];
	assign fits  = (&upper) | ~(|upper);

	always_ff @(posedge clk) begin
		if (fits) begin
			nll_s6 <= total[31:0];
		end else if (total[gpbn_pkg::TOT_W-1]) begin
			nll_s6 <= 32'sh8000_0000;
		end else begin
			nll_s6 <= 32'sh7FFF_FFFF;
		end
		sat_s6 <= ~fits;
	end

endmodule

// ===== hw/rtl/gaussian_pixel_background_nll.sv =====
// Top level of the per-pixel Gaussian background negative log-likelihood block.
// Depends on gpbn_pkg, gpbn_lane and gpbn_merge.
//
//  channel  | handshake          | word
//  ---------+--------------------+---------------------------------------------
//  input    | start, busy        | pixel_word, mean_word, icov_00..22, neg_log_norm
//  result   | done (one cycle)   | neg_log_likelihood, saturated
//
// One word is taken every clock; busy is always low.
// A word accepted at one edge passes six register stages (difference, column products,
// row sum, row weighting, lane sum, round/clip); done is high in the cycle in which
// its result is on neg_log_likelihood and saturated.
// Reset clears only the strobe pipeline; the data registers are not reset.
// The result side cannot stall, so the pipeline never holds.
module gaussian_pixel_background_nll (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [23:0] pixel_word,
	input  logic [23:0] mean_word,
	input  logic signed [31:0] icov_00,
	input  logic signed [31:0] icov_01,
	input  logic signed [31:0] icov_02,
	input  logic signed [31:0] icov_10,
	input  logic signed [31:0] icov_11,
	input  logic signed [31:0] icov_12,
	input  logic signed [31:0] icov_20,
	input  logic signed [31:0] icov_21,
	input  logic signed [31:0] icov_22,
	input  logic signed [31:0] neg_log_norm,
	output logic        done,
	output logic signed [31:0] neg_log_likelihood,
	output logic        saturated
);

	gpbn_pkg::icov_t icov_in [3][3];
	gpbn_pkg::diff_t d_s1    [gpbn_pkg::CHANNELS];
	gpbn_pkg::icov_t icov_s1 [gpbn_pkg::CHANNELS][gpbn_pkg::CHANNELS];
	gpbn_pkg::icov_t nln_s1, nln_s2, nln_s3, nln_s4;
	gpbn_pkg::lane_t lane_s4 [gpbn_pkg::CHANNELS];
	logic [gpbn_pkg::LATENCY-1:0] vld_q;

	assign busy = 1'b0;

	assign icov_in[0][0] = icov_00;
	assign icov_in[0][1] = icov_01;
	assign icov_in[0][2] = icov_02;
	assign icov_in[1][0] = icov_10;
	assign icov_in[1][1] = icov_11;
	assign icov_in[1][2] = icov_12;
	assign icov_in[2][0] = icov_20;
	assign icov_in[2][1] = icov_21;
	assign icov_in[2][2] = icov_22;

	// strobe pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[gpbn_pkg::LATENCY-2:0], start};
		end
	end

	// channel differences and operand capture
	always_ff @(posedge clk) begin
		for (int r = 0; r < gpbn_pkg::CHANNELS; r++) begin
			d_s1[r] <= $signed({1'b0, pixel_word[8*r +: 8]}) -
				$signed({1'b0, mean_word[8*r +: 8]});
			for (int c = 0; c < gpbn_pkg::CHANNELS; c++) begin
				icov_s1[r][c] <= icov_in[r][c];
			end
		end
		nln_s1 <= neg_log_norm;
		nln_s2 <= nln_s1;
		nln_s3 <= nln_s2;
		nln_s4 <= nln_s3;
	end

	// one lane per matrix row
	for (genvar r = 0; r < gpbn_pkg::CHANNELS; r++) begin : g_lane
		gpbn_lane u_lane (
			.clk      (clk),
			.d_all    (d_s1),
			.d_row    (d_s1[r]),
			.icov_row (icov_s1[r]),
			.lane_s4  (lane_s4[r])
		);
	end

	gpbn_merge u_merge (
		.clk     (clk),
		.lane_s4 (lane_s4),
		.nln_s4  (nln_s4),
		.nll_s6  (neg_log_likelihood),
		.sat_s6  (saturated)
	);

	assign done = vld_q[gpbn_pkg::LATENCY-1];

endmodule

// ===== hw/rtl/gpbn_checker.sv =====
// Port-level checker for the background likelihood block, bound to the top level.
// Depends on gpbn_pkg and gaussian_pixel_background_nll_defines.svh.
`include "gaussian_pixel_background_nll_defines.svh"

module gpbn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [23:0] pixel_word,
	input logic [23:0] mean_word,
	input logic signed [31:0] neg_log_norm,
	input logic        done,
	input logic signed [31:0] neg_log_likelihood,
	input logic        saturated
);

	logic word_taken;
	logic same_pix;
	logic on_bound;

	assign word_taken = start && !busy;
	assign same_pix   = word_taken && (pixel_word == mean_word);
	assign on_bound   = (neg_log_likelihood == 32'sh7FFF_FFFF) ||
		(neg_log_likelihood == 32'sh8000_0000);

	// never refuses a word
	`GPBN_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")

	// every accepted word gives its strobe after the pipeline depth
	`GPBN_ASSERT_DLY(a_result_follows, clk, arst_n, word_taken, gpbn_pkg::LATENCY, done, "result strobe missing")

	// a clipped result sits exactly on a bound
	`GPBN_ASSERT_IMP(a_sat_bound, clk, arst_n, done && saturated, on_bound, "saturated result off the bounds")

	// pixel equal to its mean gives the normaliser unchanged
	`GPBN_ASSERT_DLY(a_zero_diff, clk, arst_n, same_pix, gpbn_pkg::LATENCY,
		!saturated && (neg_log_likelihood == $past(neg_log_norm, gpbn_pkg::LATENCY)),
		"zero difference changed the normaliser")

endmodule

bind gaussian_pixel_background_nll gpbn_checker u_gpbn_checker (.*);
